FILE: hw/rtl/imm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imm_pkg
// Shared sizes, types and codes for the interleaved modular multiplier.
// ---------------------------------------------------------------------------
package imm_pkg;

   // Operand size in 32-bit limbs (1 to 64)
   localparam int LIMBS     = 32;
   localparam int LIMB_BITS = 32;
   localparam int IDX_W     = 6;
   localparam int LIMB_W    = (LIMBS > 1) ? $clog2(LIMBS) : 1;
   localparam int CNT_W     = $clog2(LIMBS + 1);
   localparam int NUM_BITS  = LIMBS * LIMB_BITS;
   localparam int BIT_W     = $clog2(NUM_BITS);

   typedef logic [LIMB_BITS-1:0] limb_type;
   typedef logic [LIMB_BITS:0]   wide_type;
   typedef logic [LIMB_W-1:0]    addr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MULT,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_EMIT_WAIT
   } ctl_state_type;

   // Accumulator bank that holds the current value
   typedef enum logic [1:0] {
      BANK_T,
      BANK_T_M,
      BANK_T_2M
   } bank_type;

   typedef struct packed {
      logic     load;      // input transaction accepted
      logic     start;     // accepted transaction is the last one
      logic     rd_en;     // issue a limb read
      logic     pass;      // the read belongs to a check or bit pass
      logic     op_mult;   // bit pass (else operand check pass)
      addr_type rd_addr;
      addr_type a_addr;
      logic [4:0] bit_sel;
      logic     first;     // limb 0 of a pass
      logic     last;      // most significant limb
      logic     out_load;  // load the output register
   } imm_cmd_type;

endpackage

FILE: hw/rtl/imm_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imm_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module imm_ram #(
   parameter int  WIDTH  = 32,
   parameter int  DEPTH  = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/imm_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imm_ctrl
// Sequencer: load, operand check pass, one limb pass per bit, emission.
// ---------------------------------------------------------------------------
module imm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_stall,
   input  logic                 out_taken,
   output imm_pkg::imm_cmd_type cmd
);
   import imm_pkg::*;

   ctl_state_type           state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [BIT_W-1:0]        bit_ff, bit_in;
   logic                    emitting;
   logic                    accept;
   logic                    cnt_end;
   logic                    cnt_top;

   assign emitting = (state_ff == ST_EMIT_RD) || (state_ff == ST_EMIT_LD) ||
                     (state_ff == ST_EMIT_WAIT);
   // Plain limb loads may overlap emission; the starting limb waits for idle
   assign req_stall = !((state_ff == ST_IDLE) || (emitting && !req_last));
   assign accept    = req_valid && !req_stall;
   assign cnt_end   = (cnt_ff == CNT_W'(LIMBS));
   assign cnt_top   = (cnt_ff == CNT_W'(LIMBS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         bit_ff   <= bit_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (cnt_end) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            if (cnt_end && (bit_ff == '0)) begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            state_in = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (out_taken) begin
               state_in = cnt_top ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Limb and bit counters
   always_comb begin
      cnt_in = cnt_ff;
      bit_in = bit_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_last) begin
               cnt_in = '0;
               bit_in = BIT_W'(NUM_BITS - 1);
            end
         end
         ST_CHECK: begin
            cnt_in = cnt_end ? '0 : cnt_ff + 1'b1;
         end
         ST_MULT: begin
            cnt_in = cnt_end ? '0 : cnt_ff + 1'b1;
            if (cnt_end) begin
               bit_in = bit_ff - 1'b1;
            end
         end
         ST_EMIT_WAIT: begin
            if (out_taken) begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Commands
   always_comb begin
      cmd          = '0;
      cmd.load     = accept;
      cmd.start    = accept && req_last;
      cmd.pass     = ((state_ff == ST_CHECK) || (state_ff == ST_MULT)) && !cnt_end;
      cmd.rd_en    = cmd.pass || (state_ff == ST_EMIT_RD);
      cmd.op_mult  = (state_ff == ST_MULT);
      cmd.rd_addr  = LIMB_W'(cnt_ff);
      cmd.a_addr   = (state_ff == ST_MULT) ? LIMB_W'(bit_ff >> 5) : LIMB_W'(cnt_ff);
      cmd.bit_sel  = bit_ff[4:0];
      cmd.first    = (cnt_ff == '0);
      cmd.last     = cnt_top;
      cmd.out_load = (state_ff == ST_EMIT_LD);
   end

endmodule

FILE: hw/rtl/imm_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imm_datapath
// Operand stores, three accumulator banks, limb-serial adder/subtractors
// and the output register.
// ---------------------------------------------------------------------------
module imm_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  imm_pkg::imm_cmd_type  cmd,
   input  logic [imm_pkg::IDX_W-1:0] req_limb_index,
   input  imm_pkg::limb_type     req_a_limb,
   input  imm_pkg::limb_type     req_b_limb,
   input  imm_pkg::limb_type     req_modulus_limb,
   input  logic                  rsp_stall,
   output logic                  out_taken,
   output logic                  rsp_valid,
   output imm_pkg::limb_type     rsp_result_limb,
   output logic [imm_pkg::IDX_W-1:0] rsp_result_index,
   output logic                  rsp_last_limb,
   output logic                  rsp_not_reduced
);
   import imm_pkg::*;

   limb_type   a_q, b_q, m_q;
   limb_type   acc_q  [3];
   limb_type   acc_wd [3];
   logic       store_wr;
   addr_type   store_addr;

   logic       cmp_en_ff, cmp_mult_ff, cmp_first_ff, cmp_last_ff;
   addr_type   cmp_addr_ff;
   logic       sc_ff, ac_ff, br1_ff, br2_ff, mc_ff;
   logic [1:0] top_ff;
   bank_type   cur_ff;
   logic       acc_zero_ff;
   logic       nr_ff;
   logic       rsp_valid_ff;
   limb_type   out_limb_ff;
   logic [IDX_W-1:0] out_index_ff;
   logic       out_last_ff;

   limb_type   cur_q, acc_w, shifted, addend, m2;
   logic       sc_in, ac_in, br1_in, br2_in, mc_in, a_bit;
   wide_type   sum, d1, d2, da, db;
   logic [1:0] top_t;
   logic [2:0] rhs;
   logic       fit1, fit2;

   assign store_wr   = cmd.load && (32'(req_limb_index) < LIMBS);
   assign store_addr = LIMB_W'(req_limb_index);

   imm_ram #(.WIDTH(LIMB_BITS), .DEPTH(LIMBS)) u_a_ram (
      .clock(clock), .wr_en(store_wr), .wr_addr(store_addr), .wr_data(req_a_limb),
      .rd_en(cmd.rd_en), .rd_addr(cmd.a_addr), .rd_data(a_q)
   );
   imm_ram #(.WIDTH(LIMB_BITS), .DEPTH(LIMBS)) u_b_ram (
      .clock(clock), .wr_en(store_wr), .wr_addr(store_addr), .wr_data(req_b_limb),
      .rd_en(cmd.rd_en), .rd_addr(cmd.rd_addr), .rd_data(b_q)
   );
   imm_ram #(.WIDTH(LIMB_BITS), .DEPTH(LIMBS)) u_m_ram (
      .clock(clock), .wr_en(store_wr), .wr_addr(store_addr),
      .wr_data(req_modulus_limb),
      .rd_en(cmd.rd_en), .rd_addr(cmd.rd_addr), .rd_data(m_q)
   );

   // Banks hold t, t - m and t - 2m of the latest bit pass
   for (genvar g = 0; g < 3; g++) begin : g_bank
      imm_ram #(.WIDTH(LIMB_BITS), .DEPTH(LIMBS)) u_acc_ram (
         .clock(clock), .wr_en(cmp_en_ff && cmp_mult_ff), .wr_addr(cmp_addr_ff),
         .wr_data(acc_wd[g]),
         .rd_en(cmd.rd_en), .rd_addr(cmd.rd_addr), .rd_data(acc_q[g])
      );
   end

   always_comb begin
      case (cur_ff)
         BANK_T_M:  cur_q = acc_q[1];
         BANK_T_2M: cur_q = acc_q[2];
         default:   cur_q = acc_q[0];
      endcase
   end

   // One limb of double, add, both trial subtractions and the operand check subtractions
   always_comb begin
      acc_w   = acc_zero_ff ? '0 : cur_q;
      sc_in   = cmp_first_ff ? 1'b0 : sc_ff;
      ac_in   = cmp_first_ff ? 1'b0 : ac_ff;
      br1_in  = cmp_first_ff ? 1'b0 : br1_ff;
      br2_in  = cmp_first_ff ? 1'b0 : br2_ff;
      mc_in   = cmp_first_ff ? 1'b0 : mc_ff;
      a_bit   = a_q[cmd.bit_sel];
      shifted = {acc_w[LIMB_BITS-2:0], sc_in};
      addend  = a_bit ? b_q : '0;
      m2      = {m_q[LIMB_BITS-2:0], mc_in};
      sum     = {1'b0, shifted} + {1'b0, addend} + wide_type'(ac_in);
      d1      = {1'b0, sum[LIMB_BITS-1:0]} - {1'b0, m_q} - wide_type'(br1_in);
      d2      = {1'b0, sum[LIMB_BITS-1:0]} - {1'b0, m2} - wide_type'(br2_in);
      da      = {1'b0, a_q} - {1'b0, m_q} - wide_type'(br1_in);
      db      = {1'b0, b_q} - {1'b0, m_q} - wide_type'(br2_in);
      // Top two bits of t, then whether t >= m and t >= 2m
      top_t   = {top_ff[0], acc_w[LIMB_BITS-1]} + 2'(sum[LIMB_BITS]);
      rhs     = 3'(m_q[LIMB_BITS-1]) + 3'(d2[LIMB_BITS]);
      fit1    = (top_t != 2'd0) || !d1[LIMB_BITS];
      fit2    = ({1'b0, top_t} >= rhs);
      acc_wd[0] = sum[LIMB_BITS-1:0];
      acc_wd[1] = d1[LIMB_BITS-1:0];
      acc_wd[2] = d2[LIMB_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_en_ff    <= 1'b0;
         cur_ff       <= BANK_T;
         acc_zero_ff  <= 1'b1;
         top_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmp_en_ff <= cmd.rd_en && cmd.pass;
         if (cmd.start) begin
            acc_zero_ff <= 1'b1;
            top_ff      <= 2'd0;
         end else if (cmp_en_ff && cmp_mult_ff && cmp_last_ff) begin
            acc_zero_ff <= 1'b0;
            if (fit2) begin
               cur_ff <= BANK_T_2M;
               top_ff <= 2'({1'b0, top_t} - rhs);
            end else if (fit1) begin
               cur_ff <= BANK_T_M;
               top_ff <= top_t - 2'(d1[LIMB_BITS]);
            end else begin
               cur_ff <= BANK_T;
               top_ff <= top_t;
            end
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (out_taken) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Pass pipeline and payload registers
   always_ff @(posedge clock) begin
      cmp_mult_ff  <= cmd.op_mult;
      cmp_first_ff <= cmd.first;
      cmp_last_ff  <= cmd.last;
      cmp_addr_ff  <= cmd.rd_addr;
      if (cmp_en_ff) begin
         sc_ff  <= acc_w[LIMB_BITS-1];
         ac_ff  <= sum[LIMB_BITS];
         mc_ff  <= m_q[LIMB_BITS-1];
         br1_ff <= cmp_mult_ff ? d1[LIMB_BITS] : da[LIMB_BITS];
         br2_ff <= cmp_mult_ff ? d2[LIMB_BITS] : db[LIMB_BITS];
         if (!cmp_mult_ff && cmp_last_ff) begin
            nr_ff <= !(da[LIMB_BITS] && db[LIMB_BITS]);
         end
      end
      if (cmd.out_load) begin
         out_limb_ff  <= cur_q;
         out_index_ff <= IDX_W'(cmd.rd_addr);
         out_last_ff  <= cmd.last;
      end
   end

   assign out_taken        = rsp_valid_ff && !rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_limb  = out_limb_ff;
   assign rsp_result_index = out_index_ff;
   assign rsp_last_limb    = out_last_ff;
   assign rsp_not_reduced  = nr_ff;

endmodule

FILE: hw/rtl/interleaved_modular_multiplier_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// interleaved_modular_multiplier_unit
// Interleaved modular multiplier a*b mod m over wide limb-organised operands.
// ---------------------------------------------------------------------------
// Load a, b and m one 32-bit limb of each per transaction, in any order; the
// transaction flagged last starts the multiplication, and a limb index of
// LIMBS or above is dropped. The unit then makes one pass checking that a
// and b lie below m, then works through the 32*LIMBS bits of a, most
// significant first: each bit is a single limb-serial sweep that doubles
// the accumulator, adds b when the bit is set, and forms t, t-m and t-2m
// side by side into three accumulator banks, the final borrows choosing
// which bank holds the new value. Each sweep handles one 32-bit limb slice
// per cycle. The LIMBS result limbs then leave least significant first,
// each read, loaded into the output register and held until taken before
// the next is read, with the top limb marked and not_reduced set on each
// limb if a or b was not below m. Limb loads for the next operation are
// taken while results are still leaving; the starting transaction is held
// until the last result limb has gone.
// ---------------------------------------------------------------------------
module interleaved_modular_multiplier_unit (
   input  logic                      clock,
   input  logic                      reset,
   // Operand limbs
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [imm_pkg::IDX_W-1:0] req_limb_index,
   input  imm_pkg::limb_type         req_a_limb,
   input  imm_pkg::limb_type         req_b_limb,
   input  imm_pkg::limb_type         req_modulus_limb,
   input  logic                      req_last,
   // Result limbs
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output imm_pkg::limb_type         rsp_result_limb,
   output logic [imm_pkg::IDX_W-1:0] rsp_result_index,
   output logic                      rsp_last_limb,
   output logic                      rsp_not_reduced
);
   import imm_pkg::*;

   imm_cmd_type cmd;
   logic        out_taken;

   // Sequencer: owns the input handshake, the limb and bit counters
   imm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_stall (req_stall),
      .out_taken (out_taken),
      .cmd       (cmd)
   );

   // Stores, banks, arithmetic and the result register
   imm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_limb_index   (req_limb_index),
      .req_a_limb       (req_a_limb),
      .req_b_limb       (req_b_limb),
      .req_modulus_limb (req_modulus_limb),
      .rsp_stall        (rsp_stall),
      .out_taken        (out_taken),
      .rsp_valid        (rsp_valid),
      .rsp_result_limb  (rsp_result_limb),
      .rsp_result_index (rsp_result_index),
      .rsp_last_limb    (rsp_last_limb),
      .rsp_not_reduced  (rsp_not_reduced)
   );

endmodule

FILE: tb/interleaved_modular_multiplier_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// interleaved_modular_multiplier_unit_tb
// Self-checking bench for the limb-serial modular multiplier a*b mod m.
// ---------------------------------------------------------------------------
// The bench loads operand limbs through the request channel. It keeps its own
// copy of the three operand stores and its own wide-integer model of the
// double / add / reduce loop. Every accepted starting transaction queues
// LIMBS expected result limbs. A checker compares each accepted result
// transaction, field by field, against the oldest queued limb. The stimulus
// runs in this order: directed corner cases, random operand sets under four
// idling mixes, and a back-pressure test.
// ---------------------------------------------------------------------------
module interleaved_modular_multiplier_unit_tb;
   import imm_pkg::*;

   localparam int RESET_CYCLES   = 9;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int SETTLE_CYCLES  = 200;
   // Seventeen products are run, so this ceiling leaves a wide margin.
   localparam int TIMEOUT_CYCLES = 3_000_000;

   typedef logic [NUM_BITS-1:0] operand_type;
   typedef logic [NUM_BITS+1:0] accum_type;
   typedef logic [IDX_W-1:0]    index_type;

   typedef struct packed {
      limb_type  limb;
      index_type index;
      logic      top;
      logic      not_reduced;
   } result_limb_type;

   // Every input is given a known value from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   index_type   req_limb_index = '0;
   limb_type    req_a_limb = '0;
   limb_type    req_b_limb = '0;
   limb_type    req_modulus_limb = '0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   limb_type    rsp_result_limb;
   index_type   rsp_result_index;
   logic        rsp_last_limb;
   logic        rsp_not_reduced;

   // Bench copy of the operand stores, and the queue of result limbs still owed
   operand_type       multiplier_copy  = '0;
   operand_type       multiplicand_copy = '0;
   operand_type       modulus_copy     = '0;
   result_limb_type   expected_limbs[$];

   // Idling controls: percentages of cycles spent idle or stalled
   int idle_pct  = 0;
   int stall_pct = 0;
   // A long hold-off is requested by bumping the request count
   int holdoff_requests = 0;
   int holdoffs_done    = 0;
   int holdoff_left     = 0;

   int items_accepted  = 0;
   int products_started = 0;
   int limbs_checked   = 0;
   int mismatches      = 0;

   interleaved_modular_multiplier_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_limb_index   (req_limb_index),
      .req_a_limb       (req_a_limb),
      .req_b_limb       (req_b_limb),
      .req_modulus_limb (req_modulus_limb),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_limb  (rsp_result_limb),
      .rsp_result_index (rsp_result_index),
      .rsp_last_limb    (rsp_last_limb),
      .rsp_not_reduced  (rsp_not_reduced)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Fixed ceiling on the run. It fires only if the block hangs.
   initial begin
      repeat (TIMEOUT_CYCLES) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   // Apply one accepted transaction to the bench's stores. On a starting
   // transaction, run the interleaved loop over all 32*LIMBS bits of a and
   // queue the LIMBS result limbs. The accumulator carries two extra bits and
   // wraps at that width. This matters when the operands are not reduced.
   task automatic absorb_limb(input index_type idx, input limb_type a, input limb_type b,
                              input limb_type m, input logic start);
      accum_type       acc;
      logic            unreduced;
      result_limb_type item;
      if (idx < LIMBS) begin
         multiplier_copy[idx*LIMB_BITS +: LIMB_BITS]   = a;
         multiplicand_copy[idx*LIMB_BITS +: LIMB_BITS] = b;
         modulus_copy[idx*LIMB_BITS +: LIMB_BITS]      = m;
      end
      if (start) begin
         unreduced = !((multiplier_copy < modulus_copy) && (multiplicand_copy < modulus_copy));
         acc = '0;
         for (int k = NUM_BITS - 1; k >= 0; k--) begin
            acc = acc << 1;
            if (multiplier_copy[k]) acc = acc + {2'b00, multiplicand_copy};
            // At most two subtractions of m bring the sum back below m
            repeat (2) begin
               if (acc >= {2'b00, modulus_copy}) acc = acc - {2'b00, modulus_copy};
            end
         end
         for (int i = 0; i < LIMBS; i++) begin
            item.limb        = acc[i*LIMB_BITS +: LIMB_BITS];
            item.index       = index_type'(i);
            item.top         = (i == LIMBS - 1);
            item.not_reduced = unreduced;
            expected_limbs.push_back(item);
         end
         products_started++;
      end
   endtask

   // Offer one limb transaction. Drive at the falling edge and hold the
   // payload until a rising edge sees the stall low.
   task automatic send_limb(input index_type idx, input limb_type a, input limb_type b,
                            input limb_type m, input logic start);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_limb_index   <= idx;
      req_a_limb       <= a;
      req_b_limb       <= b;
      req_modulus_limb <= m;
      req_last         <= start;
      do @(posedge clock); while (req_stall);
      items_accepted++;
      absorb_limb(idx, a, b, m, start);
   endtask

   // Drop valid, then wait until every queued result limb has been checked
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_limbs.size() != 0) @(posedge clock);
   endtask

   // Send one set of operand limbs that ends in a starting transaction.
   // A full load writes every limb position in shuffled order. It draws a
   // modulus of random length and, most of the time, operands reduced below
   // it. Stray transactions with out-of-range indexes are mixed in. A partial
   // load rewrites a few random positions of the stored operands.
   task automatic send_operand_set(input bit full_load);
      operand_type a_new;
      operand_type b_new;
      operand_type m_new;
      int          order[LIMBS];
      int          span;
      int          pick;
      int          swap;
      int          count;
      int          top_pos;
      limb_type    m_top;
      index_type   idx;
      bit          stray_start;
      if (full_load) begin
         span  = $urandom_range(1) ? LIMBS : $urandom_range(LIMBS, 1);
         a_new = '0;
         b_new = '0;
         m_new = '0;
         for (int i = 0; i < span; i++) begin
            a_new[i*LIMB_BITS +: LIMB_BITS] = $urandom;
            b_new[i*LIMB_BITS +: LIMB_BITS] = $urandom;
            m_new[i*LIMB_BITS +: LIMB_BITS] = $urandom;
         end
         top_pos = (span - 1) * LIMB_BITS;
         case ($urandom_range(3))
            0: begin
               m_top = '1;
            end
            1: begin
               m_top = 1;
            end
            default: begin
               m_top = m_new[top_pos +: LIMB_BITS];
               if (m_top == 0) m_top = 1;
            end
         endcase
         m_new[top_pos +: LIMB_BITS] = m_top;
         a_new[top_pos +: LIMB_BITS] = $urandom_range(m_top);
         b_new[top_pos +: LIMB_BITS] = $urandom_range(m_top);
         if ($urandom_range(99) < 15) begin
            // Push the top limb of a to or past that of m
            a_new[top_pos +: LIMB_BITS] = $urandom_range(32'hFFFF_FFFF, m_top);
         end else begin
            if (a_new >= m_new) a_new = a_new - m_new;
            if (b_new >= m_new) b_new = b_new - m_new;
            if ($urandom_range(9) == 0) a_new = m_new - 1;
         end
         for (int i = 0; i < LIMBS; i++) order[i] = i;
         for (int i = LIMBS - 1; i > 0; i--) begin
            pick        = $urandom_range(i);
            swap        = order[i];
            order[i]    = order[pick];
            order[pick] = swap;
         end
         // Sometimes start from a stray index instead of a real limb
         stray_start = ($urandom_range(9) == 0);
         for (int i = 0; i < LIMBS; i++) begin
            if ($urandom_range(7) == 0)
               send_limb(index_type'($urandom_range(63, LIMBS)), $urandom, $urandom,
                         $urandom, 1'b0);
            idx = index_type'(order[i]);
            send_limb(idx, a_new[idx*LIMB_BITS +: LIMB_BITS], b_new[idx*LIMB_BITS +: LIMB_BITS],
                      m_new[idx*LIMB_BITS +: LIMB_BITS], (i == LIMBS - 1) && !stray_start);
         end
         if (stray_start)
            send_limb(index_type'($urandom_range(63, LIMBS)), $urandom, $urandom,
                      $urandom, 1'b1);
      end else begin
         count = $urandom_range(6, 1);
         for (int i = 0; i < count; i++) begin
            idx   = index_type'($urandom_range(LIMBS - 1));
            m_top = ($urandom_range(4) == 0) ? limb_type'($urandom)
                                             : modulus_copy[idx*LIMB_BITS +: LIMB_BITS];
            send_limb(idx, $urandom >> $urandom_range(31), $urandom >> $urandom_range(31),
                      m_top, i == count - 1);
         end
      end
   endtask

   // Largest reduced operands: m all ones, a = b = m - 1, loaded in order
   task automatic test_extreme_operands();
      operand_type m_all;
      operand_type a_max;
      idle_pct  = 0;
      stall_pct = 0;
      m_all = '1;
      a_max = m_all - 1;
      for (int i = 0; i < LIMBS; i++)
         send_limb(index_type'(i), a_max[i*LIMB_BITS +: LIMB_BITS],
                   a_max[i*LIMB_BITS +: LIMB_BITS], m_all[i*LIMB_BITS +: LIMB_BITS],
                   i == LIMBS - 1);
      wait_for_results();
   endtask

   // Out-of-range indexes: drop the limbs, but still start when last is set
   task automatic test_ignored_index();
      send_limb('1, '1, '1, '1, 1'b1);
      send_limb(index_type'(LIMBS), '1, '1, '1, 1'b0);
      send_limb('0, '0, 32'hFFFF_FFFE, '1, 1'b1);
      wait_for_results();
   endtask

   // Unreduced operands: a above m, then b exactly equal to m
   task automatic test_not_reduced();
      send_limb(index_type'(LIMBS - 1), '1, '0, 32'hFFFF_FFFE, 1'b1);
      wait_for_results();
      send_limb('0, '0, '1, '1, 1'b0);
      send_limb(index_type'(LIMBS - 1), '0, '1, '1, 1'b1);
      wait_for_results();
   endtask

   // Zero modulus: every compare passes and subtracts nothing
   task automatic test_zero_modulus();
      for (int i = LIMBS - 1; i >= 0; i--)
         send_limb(index_type'(i), $urandom, $urandom, '0, i == 0);
      wait_for_results();
   endtask

   // One full and one partial operand set under a given idling mix
   task automatic test_random_traffic(input int idle, input int stall);
      idle_pct  = idle;
      stall_pct = stall;
      send_operand_set(1'b1);
      send_operand_set(1'b0);
      wait_for_results();
   endtask

   // Hold the results of one product off for a long stretch. Meanwhile the
   // next set is offered, so loads pile up and the starting transaction
   // stalls. Then pause the sender until all results are in, and send once
   // more from a drained block.
   task automatic test_backpressure();
      idle_pct  = 0;
      stall_pct = 0;
      send_operand_set(1'b0);
      holdoff_requests++;
      send_operand_set(1'b1);
      wait_for_results();
      send_operand_set(1'b0);
      wait_for_results();
   endtask

   // Receiver: change the stall at the falling edge. A requested hold-off
   // begins with the first result on offer and keeps the stall high until its counter runs out.
   always @(negedge clock) begin
      if (holdoff_left > 0) begin
         rsp_stall <= 1'b1;
         holdoff_left--;
      end else if (holdoff_requests > holdoffs_done && rsp_valid) begin
         rsp_stall <= 1'b1;
         holdoffs_done++;
         holdoff_left = HOLDOFF_CYCLES - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Checker: compare each accepted result transaction with the oldest expectation
   always @(posedge clock) begin
      result_limb_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_limbs.size() == 0) begin
            $error("unexpected result limb %h at index %0d", rsp_result_limb, rsp_result_index);
            mismatches++;
         end else begin
            want = expected_limbs.pop_front();
            limbs_checked++;
            if (rsp_result_limb !== want.limb) begin
               $error("result_limb: expected %h, got %h", want.limb, rsp_result_limb);
               mismatches++;
            end
            if (rsp_result_index !== want.index) begin
               $error("result_index: expected %0d, got %0d", want.index, rsp_result_index);
               mismatches++;
            end
            if (rsp_last_limb !== want.top) begin
               $error("last_limb: expected %b, got %b", want.top, rsp_last_limb);
               mismatches++;
            end
            if (rsp_not_reduced !== want.not_reduced) begin
               $error("not_reduced: expected %b, got %b", want.not_reduced, rsp_not_reduced);
               mismatches++;
            end
         end
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_extreme_operands();
      test_ignored_index();
      test_not_reduced();
      test_zero_modulus();
      test_random_traffic(0, 0);
      test_random_traffic(79, 0);
      test_random_traffic(0, 79);
      test_random_traffic(19, 19);
      test_backpressure();

      // Allow any stray extra result to show up before the verdict
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Run covered %0d limb transactions, %0d products, %0d result limbs compared.",
               items_accepted, products_started, limbs_checked);
      $display("Corners: extreme, stray-index, unreduced and zero-modulus operands; %s",
               "four idling mixes and a long hold-off.");
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: interleaved_modular_multiplier_unit.f
hw/rtl/imm_pkg.sv
hw/rtl/imm_ram.sv
hw/rtl/imm_ctrl.sv
hw/rtl/imm_datapath.sv
hw/rtl/interleaved_modular_multiplier_unit.sv
tb/interleaved_modular_multiplier_unit_tb.sv
